/* rtl/m3sh_pkg.sv */
// Shared types and constants for the streaming MurmurHash3 body core.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package m3sh_pkg;

    localparam int WORD_W      = 32;
    localparam int COUNT_W     = 3;
    localparam int CFG_IDX_W   = 2;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_SEED       = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MULT_FIRST  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MULT_SECOND = 2'd2;

    localparam logic [WORD_W-1:0] MULT_FIRST_RESET  = 32'hcc9e2d51;
    localparam logic [WORD_W-1:0] MULT_SECOND_RESET = 32'h1b873593;
    localparam logic [WORD_W-1:0] HASH_ADD_CONST    = 32'he6546b64;
    localparam int KEY_ROT  = 15;
    localparam int HASH_ROT = 13;

    localparam logic [COUNT_W-1:0] FULL_WORD_BYTES = 3'd4;

    typedef struct packed {
        logic [WORD_W-1:0] key;
        logic              full;
        logic              ends;
    } item_t;

    typedef struct packed {
        logic [WORD_W-1:0] seed;
        logic [WORD_W-1:0] mult_first;
        logic [WORD_W-1:0] mult_second;
    } cfg_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL1,
        ST_MUL2,
        ST_UPDATE,
        ST_OUT
    } back_state_t;

    function automatic logic [WORD_W-1:0] rotl(input logic [WORD_W-1:0] x, input int r);
        rotl = (x << r) | (x >> (WORD_W - r));
    endfunction

endpackage

/* rtl/murmur3_stream_hash_body_core.sv */
// Top level of the streaming MurmurHash3 x86_32 body core (no final avalanche).
// Depends on m3sh_pkg, m3sh_front, m3sh_queue and m3sh_back.
`timescale 1ns / 1ps

// Each input beat carries up to four little-endian message bytes. The front end
// masks and classifies a beat in the cycle it is accepted and places it in a
// two-entry queue, so s_ready stays high while the queue has room. The back end
// takes one beat at a time and works through it in order: a load in ST_IDLE,
// the two key multiplications (seed-independent mixing) in ST_MUL1 and ST_MUL2,
// then the hash update in ST_UPDATE, and takes no new beat until it is through
// with the last. A beat that ends the message (a tail of 0 to 3 bytes, or last
// set) holds m_valid until m_ready, before the next beat. Configuration writes
// take effect at once and are meant to happen only while the core is idle.

module murmur3_stream_hash_body_core (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_we,
    input  logic [m3sh_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [m3sh_pkg::WORD_W-1:0]    cfg_wdata,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic [m3sh_pkg::WORD_W-1:0]    s_data_word,
    input  logic [m3sh_pkg::COUNT_W-1:0]   s_valid_bytes,
    input  logic                           s_last,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [m3sh_pkg::WORD_W-1:0]    m_hash_value
);
    import m3sh_pkg::*;

    cfg_t  cfg_reg, cfg_next;
    logic  push_valid, push_ready;
    item_t push_item;
    logic  pop_valid, pop_ready;
    item_t pop_item;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_we) begin
            case (cfg_index)
                CFG_SEED:        cfg_next.seed        = cfg_wdata;
                CFG_MULT_FIRST:  cfg_next.mult_first  = cfg_wdata;
                CFG_MULT_SECOND: cfg_next.mult_second = cfg_wdata;
                default:         cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.seed        <= '0;
            cfg_reg.mult_first  <= MULT_FIRST_RESET;
            cfg_reg.mult_second <= MULT_SECOND_RESET;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    m3sh_front u_front (
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_data_word   (s_data_word),
        .s_valid_bytes (s_valid_bytes),
        .s_last        (s_last),
        .push_valid    (push_valid),
        .push_ready    (push_ready),
        .push_item     (push_item)
    );

    m3sh_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_item  (push_item),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_item   (pop_item)
    );

    m3sh_back u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg          (cfg_reg),
        .pop_valid    (pop_valid),
        .pop_ready    (pop_ready),
        .pop_item     (pop_item),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_hash_value (m_hash_value)
    );

endmodule

/* rtl/m3sh_front.sv */
// Front end: accepts input beats, masks tail bytes and classifies each beat.
// Depends on m3sh_pkg; feeds m3sh_queue.
`timescale 1ns / 1ps

module m3sh_front (
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic [m3sh_pkg::WORD_W-1:0]    s_data_word,
    input  logic [m3sh_pkg::COUNT_W-1:0]   s_valid_bytes,
    input  logic                           s_last,
    output logic                           push_valid,
    input  logic                           push_ready,
    output m3sh_pkg::item_t                push_item
);
    import m3sh_pkg::*;

    logic [WORD_W-1:0] mask;
    logic              full;

    always_comb begin
        full = (s_valid_bytes >= FULL_WORD_BYTES);
        case (s_valid_bytes)
            3'd0:    mask = 32'h0000_0000;
            3'd1:    mask = 32'h0000_00ff;
            3'd2:    mask = 32'h0000_ffff;
            3'd3:    mask = 32'h00ff_ffff;
            default: mask = 32'hffff_ffff;
        endcase
    end

    assign s_ready          = push_ready;
    assign push_valid       = s_valid;
    assign push_item.key    = s_data_word & mask;
    assign push_item.full   = full;
    assign push_item.ends   = !full || s_last;

endmodule

/* rtl/m3sh_queue.sv */
// Short register queue of classified beats between front and back end.
// Depends on m3sh_pkg for the item type and depth.
`timescale 1ns / 1ps

module m3sh_queue (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            push_valid,
    output logic            push_ready,
    input  m3sh_pkg::item_t push_item,
    output logic            pop_valid,
    input  logic            pop_ready,
    output m3sh_pkg::item_t pop_item
);
    import m3sh_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    item_t             entry_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              do_push, do_pop;

    assign push_ready = (count_reg != CNT_W'(QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_item   = entry_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                  : wr_ptr_reg + PTR_W'(1);
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                  : rd_ptr_reg + PTR_W'(1);
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + CNT_W'(1);
        end else if (do_pop && !do_push) begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

/* rtl/m3sh_back.sv */
// Back end: key mixing over two multiplier steps, hash update and result beat.
// Depends on m3sh_pkg; drains m3sh_queue.
`timescale 1ns / 1ps

module m3sh_back (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  m3sh_pkg::cfg_t               cfg,
    input  logic                         pop_valid,
    output logic                         pop_ready,
    input  m3sh_pkg::item_t              pop_item,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [m3sh_pkg::WORD_W-1:0]  m_hash_value
);
    import m3sh_pkg::*;

    back_state_t       state_reg, state_next;
    logic [WORD_W-1:0] key_reg, key_next;
    logic [WORD_W-1:0] hash_reg, hash_next;
    logic              full_reg, full_next;
    logic              ends_reg, ends_next;
    logic              start_reg, start_next;
    logic [WORD_W-1:0] mixed_hash;
    logic [WORD_W-1:0] rot_hash;

    always_comb begin
        mixed_hash = (start_reg ? cfg.seed : hash_reg) ^ key_reg;
        rot_hash   = rotl(mixed_hash, HASH_ROT);
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:   if (pop_valid) state_next = ST_MUL1;
            ST_MUL1:   state_next = ST_MUL2;
            ST_MUL2:   state_next = ST_UPDATE;
            ST_UPDATE: state_next = ends_reg ? ST_OUT : ST_IDLE;
            ST_OUT:    if (m_ready) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        pop_ready  = 1'b0;
        m_valid    = 1'b0;
        key_next   = key_reg;
        hash_next  = hash_reg;
        full_next  = full_reg;
        ends_next  = ends_reg;
        start_next = start_reg;
        case (state_reg)
            ST_IDLE: begin
                pop_ready = 1'b1;
                key_next  = pop_item.key;
                full_next = pop_item.full;
                ends_next = pop_item.ends;
            end
            ST_MUL1: begin
                key_next = key_reg * cfg.mult_first;
            end
            ST_MUL2: begin
                key_next = rotl(key_reg, KEY_ROT) * cfg.mult_second;
            end
            ST_UPDATE: begin
                hash_next  = full_reg ? ((rot_hash << 2) + rot_hash + HASH_ADD_CONST)
                                      : mixed_hash;
                start_next = ends_reg;
            end
            ST_OUT: begin
                m_valid = 1'b1;
            end
            default: begin
            end
        endcase
    end

    assign m_hash_value = hash_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            start_reg <= 1'b1;
            hash_reg  <= '0;
        end else begin
            state_reg <= state_next;
            start_reg <= start_next;
            hash_reg  <= hash_next;
        end
    end

    always_ff @(posedge aclk) begin
        key_reg  <= key_next;
        full_reg <= full_next;
        ends_reg <= ends_next;
    end

endmodule
